FILE: src/kabf_pkg.sv
// Package for the angle/bias Kalman filter: sequencer states, register
// indexes, fixed-point constants and saturation helpers. No dependencies.
`timescale 1ns / 1ps
package kabf_pkg;

  localparam int unsigned CovFracBits = 30;
  localparam int unsigned DivBits     = 62;
  localparam int unsigned CntW        = 6;

  localparam logic [29:0] AngleNoiseRst = 30'd10737418;
  localparam logic [29:0] BiasNoiseRst  = 30'd3221225;
  localparam logic [29:0] MeasNoiseRst  = 30'd10737418;

  localparam logic [1:0] RegAngleNoise = 2'd0;
  localparam logic [1:0] RegBiasNoise  = 2'd1;
  localparam logic [1:0] RegMeasNoise  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_M1, ST_A1, ST_M2, ST_A2, ST_M3, ST_A3, ST_M4, ST_A4,
    ST_DSETUP, ST_D0, ST_DF0, ST_D1, ST_DF1,
    ST_M5, ST_A5, ST_M6, ST_A6, ST_M7, ST_A7, ST_M8, ST_A8,
    ST_M9, ST_A9, ST_M10, ST_A10, ST_OUT
  } state_e;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sd2147483647;
    lo = -40'sd2147483648;
    if (v > hi) sat32 = 32'sh7FFFFFFF;
    else if (v < lo) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  // Apply sign to a quotient magnitude and clamp to 32 bits
  function automatic logic signed [31:0] sat_quot(input logic [DivBits-1:0] q,
                                                  input logic neg);
    logic [DivBits-1:0] lim;
    lim = DivBits'(64'd2147483648);
    if (neg) begin
      if (q >= lim) sat_quot = 32'sh80000000;
      else sat_quot = -$signed(q[31:0]);
    end else begin
      if (q >= lim) sat_quot = 32'sh7FFFFFFF;
      else sat_quot = $signed(q[31:0]);
    end
  endfunction

endpackage

FILE: src/kalman_angle_bias_filter_unit.sv
// Two-state Kalman filter (angle and gyro bias) with one shared multiplier
// and a bit-serial divider under a sequencer. Depends on kabf_pkg.
`timescale 1ns / 1ps
// Usage:
//   s_axis carries one sample item: measured angle and rate (Q16.16) and the
//   time step (Q2.30). m_axis returns one filtered angle (Q16.16) per item.
//   The APB port writes the three noise registers at 0x0, 0x4 and 0x8; write
//   them only while the filter is idle.
// Sequence:
//   An item passes ten products through the single 33x32 multiplier, each
//   a multiply step and an accumulate step, and two gain divisions in the
//   restoring divider, each a run of quotient steps and one finish step.
//   With a zero innovation variance the divisions are skipped.
//   s_axis_tready is high only while the sequencer is idle, so one item is
//   in work at a time; the next item may enter while the result waits.
// Reset:
//   rst_ni clears the estimates and covariance to zero and loads the noise
//   registers with their defaults.
// Stall:
//   A finished result sits in the output register until taken; a following
//   item stops at its end until the register frees.
module kalman_angle_bias_filter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // s_axis_tdata: [31:0] measured_angle, [63:32] measured_rate,
  // [94:64] time_step, [95] zero
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,
  // m_axis_tdata: [31:0] filtered_angle
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned Cfb = kabf_pkg::CovFracBits;
  localparam int unsigned Db  = kabf_pkg::DivBits;

  kabf_pkg::state_e state_q, state_d;

  logic [29:0] qa_q, qb_q, rn_q;
  logic signed [31:0] angle_q, bias_q, aa_q, ab_q, ba_q, bb_q;
  logic signed [31:0] meas_q, rate_q, dt_q;
  logic signed [31:0] bracket_q, innov_q, k0_q, k1_q, p00_q, p01_q;
  logic signed [33:0] s_q;
  logic signed [64:0] prod_q;
  logic [31:0]        rem_q, dabs_q;
  logic [Db-1:0]      dq_q;
  logic [kabf_pkg::CntW-1:0] cnt_q;
  logic               dneg_q;
  logic [31:0]        out_q;
  logic               out_valid_q;

  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [35:0] qres;
  logic signed [65:0] rnd;
  logic [32:0]        shifted;
  logic [33:0]        trial;
  logic               div_last;
  logic               wr_en;
  logic signed [33:0] s_d;
  logic signed [33:0] s_abs;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Read back the noise registers
  always_comb begin
    case (paddr[3:2])
      kabf_pkg::RegAngleNoise: prdata = {2'b00, qa_q};
      kabf_pkg::RegBiasNoise:  prdata = {2'b00, qb_q};
      kabf_pkg::RegMeasNoise:  prdata = {2'b00, rn_q};
      default:                 prdata = 32'd0;
    endcase
  end

  // Rounded product: add half, then floor shift
  assign rnd  = {prod_q[64], prod_q} + 66'sd536870912;
  assign qres = rnd[65:Cfb];

  // Divider step and innovation variance
  assign shifted  = {rem_q, dq_q[Db-1]};
  assign trial    = {1'b0, shifted} - {2'b00, dabs_q};
  assign div_last = (cnt_q == kabf_pkg::CntW'(Db - 1));
  assign s_d      = 34'(aa_q) + 34'(signed'({4'b0000, rn_q}));
  assign s_abs    = s_q[33] ? -s_q : s_q;

  // Select multiplier operands for the current step
  always_comb begin
    mul_a = 33'sd0;
    mul_b = dt_q;
    case (state_q)
      kabf_pkg::ST_M1:  mul_a = 33'(rate_q) - 33'(bias_q);
      kabf_pkg::ST_M2:  mul_a = 33'(bb_q);
      kabf_pkg::ST_M3:  mul_a = 33'(bracket_q);
      kabf_pkg::ST_M4:  mul_a = signed'({3'b000, qb_q});
      kabf_pkg::ST_M5:  begin mul_a = 33'(innov_q); mul_b = k0_q; end
      kabf_pkg::ST_M6:  begin mul_a = 33'(innov_q); mul_b = k1_q; end
      kabf_pkg::ST_M7:  begin mul_a = 33'(p00_q);   mul_b = k0_q; end
      kabf_pkg::ST_M8:  begin mul_a = 33'(p01_q);   mul_b = k0_q; end
      kabf_pkg::ST_M9:  begin mul_a = 33'(p00_q);   mul_b = k1_q; end
      kabf_pkg::ST_M10: begin mul_a = 33'(p01_q);   mul_b = k1_q; end
      default:          mul_a = 33'sd0;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      kabf_pkg::ST_IDLE:   if (s_axis_tvalid) state_d = kabf_pkg::ST_M1;
      kabf_pkg::ST_M1:     state_d = kabf_pkg::ST_A1;
      kabf_pkg::ST_A1:     state_d = kabf_pkg::ST_M2;
      kabf_pkg::ST_M2:     state_d = kabf_pkg::ST_A2;
      kabf_pkg::ST_A2:     state_d = kabf_pkg::ST_M3;
      kabf_pkg::ST_M3:     state_d = kabf_pkg::ST_A3;
      kabf_pkg::ST_A3:     state_d = kabf_pkg::ST_M4;
      kabf_pkg::ST_M4:     state_d = kabf_pkg::ST_A4;
      kabf_pkg::ST_A4:     state_d = kabf_pkg::ST_DSETUP;
      kabf_pkg::ST_DSETUP: state_d = (s_q == 34'sd0) ? kabf_pkg::ST_M5 : kabf_pkg::ST_D0;
      kabf_pkg::ST_D0:     if (div_last) state_d = kabf_pkg::ST_DF0;
      kabf_pkg::ST_DF0:    state_d = kabf_pkg::ST_D1;
      kabf_pkg::ST_D1:     if (div_last) state_d = kabf_pkg::ST_DF1;
      kabf_pkg::ST_DF1:    state_d = kabf_pkg::ST_M5;
      kabf_pkg::ST_M5:     state_d = kabf_pkg::ST_A5;
      kabf_pkg::ST_A5:     state_d = kabf_pkg::ST_M6;
      kabf_pkg::ST_M6:     state_d = kabf_pkg::ST_A6;
      kabf_pkg::ST_A6:     state_d = kabf_pkg::ST_M7;
      kabf_pkg::ST_M7:     state_d = kabf_pkg::ST_A7;
      kabf_pkg::ST_A7:     state_d = kabf_pkg::ST_M8;
      kabf_pkg::ST_M8:     state_d = kabf_pkg::ST_A8;
      kabf_pkg::ST_A8:     state_d = kabf_pkg::ST_M9;
      kabf_pkg::ST_M9:     state_d = kabf_pkg::ST_A9;
      kabf_pkg::ST_A9:     state_d = kabf_pkg::ST_M10;
      kabf_pkg::ST_M10:    state_d = kabf_pkg::ST_A10;
      kabf_pkg::ST_A10:    state_d = kabf_pkg::ST_OUT;
      kabf_pkg::ST_OUT:    if (!out_valid_q || m_axis_tready) state_d = kabf_pkg::ST_IDLE;
      default:             state_d = kabf_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    s_axis_tready = (state_q == kabf_pkg::ST_IDLE);
    m_axis_tvalid = out_valid_q;
    m_axis_tdata  = out_q;
  end

  // Control state, noise registers and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kabf_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      qa_q        <= kabf_pkg::AngleNoiseRst;
      qb_q        <= kabf_pkg::BiasNoiseRst;
      rn_q        <= kabf_pkg::MeasNoiseRst;
      angle_q     <= '0;
      bias_q      <= '0;
      aa_q        <= '0;
      ab_q        <= '0;
      ba_q        <= '0;
      bb_q        <= '0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        case (paddr[3:2])
          kabf_pkg::RegAngleNoise: qa_q <= pwdata[29:0];
          kabf_pkg::RegBiasNoise:  qb_q <= pwdata[29:0];
          kabf_pkg::RegMeasNoise:  rn_q <= pwdata[29:0];
          default: ;
        endcase
      end
      // Load the result register, or free it once taken
      if (state_q == kabf_pkg::ST_OUT && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        kabf_pkg::ST_A1: angle_q <= kabf_pkg::sat32(40'(angle_q) + 40'(qres));
        kabf_pkg::ST_A2: begin
          ab_q <= kabf_pkg::sat32(40'(ab_q) - 40'(qres));
          ba_q <= kabf_pkg::sat32(40'(ba_q) - 40'(qres));
        end
        kabf_pkg::ST_A3: aa_q <= kabf_pkg::sat32(40'(aa_q) + 40'(qres));
        kabf_pkg::ST_A4: bb_q <= kabf_pkg::sat32(40'(bb_q) + 40'(qres));
        kabf_pkg::ST_DSETUP, kabf_pkg::ST_DF0: cnt_q <= '0;
        kabf_pkg::ST_D0, kabf_pkg::ST_D1: cnt_q <= cnt_q + 1'b1;
        kabf_pkg::ST_A5: angle_q <= kabf_pkg::sat32(40'(angle_q) + 40'(qres));
        kabf_pkg::ST_A6: bias_q <= kabf_pkg::sat32(40'(bias_q) + 40'(qres));
        kabf_pkg::ST_A7: aa_q <= kabf_pkg::sat32(40'(aa_q) - 40'(qres));
        kabf_pkg::ST_A8: ab_q <= kabf_pkg::sat32(40'(ab_q) - 40'(qres));
        kabf_pkg::ST_A9: ba_q <= kabf_pkg::sat32(40'(ba_q) - 40'(qres));
        kabf_pkg::ST_A10: bb_q <= kabf_pkg::sat32(40'(bb_q) - 40'(qres));
        default: ;
      endcase
    end
  end

  // Datapath registers: sample, temporaries, product and divider
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * 65'(mul_b);
    case (state_q)
      kabf_pkg::ST_IDLE: begin
        meas_q <= s_axis_tdata[31:0];
        rate_q <= s_axis_tdata[63:32];
        dt_q   <= {1'b0, s_axis_tdata[94:64]};
      end
      kabf_pkg::ST_A2: bracket_q <= kabf_pkg::sat32(40'(qres) - 40'(ab_q) - 40'(ba_q)
                                                   + 40'(signed'({1'b0, qa_q})));
      kabf_pkg::ST_A4: begin
        innov_q <= kabf_pkg::sat32(40'(meas_q) - 40'(angle_q));
        s_q     <= s_d;
      end
      kabf_pkg::ST_DSETUP: begin
        k0_q   <= '0;
        k1_q   <= '0;
        p00_q  <= aa_q;
        p01_q  <= ab_q;
        rem_q  <= '0;
        dabs_q <= s_abs[31:0];
        dneg_q <= aa_q[31] ^ s_q[33];
        dq_q   <= {(aa_q[31] ? 32'(-33'(aa_q)) : 32'(aa_q)), {Cfb{1'b0}}};
      end
      kabf_pkg::ST_D0, kabf_pkg::ST_D1: begin
        if (!trial[33]) begin
          rem_q <= trial[31:0];
          dq_q  <= {dq_q[Db-2:0], 1'b1};
        end else begin
          rem_q <= shifted[31:0];
          dq_q  <= {dq_q[Db-2:0], 1'b0};
        end
      end
      kabf_pkg::ST_DF0: begin
        k0_q   <= kabf_pkg::sat_quot(dq_q, dneg_q);
        rem_q  <= '0;
        dneg_q <= ba_q[31] ^ s_q[33];
        dq_q   <= {(ba_q[31] ? 32'(-33'(ba_q)) : 32'(ba_q)), {Cfb{1'b0}}};
      end
      kabf_pkg::ST_DF1: k1_q <= kabf_pkg::sat_quot(dq_q, dneg_q);
      kabf_pkg::ST_OUT: if (!out_valid_q || m_axis_tready) out_q <= angle_q;
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == kabf_pkg::ST_OUT))
    else $error("result raised outside the output step");
  a_zero_div_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kabf_pkg::ST_DSETUP && s_q == 34'sd0) |=> (k0_q == 32'sd0 && k1_q == 32'sd0))
    else $error("gains not cleared for zero variance");
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != kabf_pkg::ST_IDLE) |-> !s_axis_tready)
    else $error("ready while an item is in work");
`endif

endmodule
